// ----- hdl/kwmh_pkg.sv -----
`default_nettype none

package kwmh_pkg;

    localparam int KEY_W               = 63;
    localparam int SID_W               = 4;
    localparam int DEFAULT_MAX_STREAMS = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SID_W-1:0] sid;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_END     = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BOUND,
        S_DECIDE,
        S_DROP,
        S_DROP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_UP_CHK,
        S_UP_CMP,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/k_way_merge_heap.sv -----
// Min-heap merge of up to MAX_STREAMS ascending key streams.
// Input channel (i_valid/o_ready) carries one command: insert an entry,
// advance the head stream with its next key, end the head stream, or clear.
// Register max_gap is written through i_cfg_we/i_cfg_data; the user
// must do so only while idle, as the block does not enforce it. Every
// command gives exactly one result on the output channel
// (o_valid/i_ready): the head entry, the entry count and a status.
// Sifting walks the heap one level at a time: each level reads the
// children (or the parent) from the two-read-port heap RAM in S_DN_RD
// or S_UP_CHK, then the key compares decide and write back in S_DN_CMP
// or S_UP_CMP.
// One command is worked on at a time; o_ready is high only while idle,
// so a new command is taken only once the last result has left FINISH.
// A finished result waits in the output register while the next command
// is already taken; if the receiver stalls with a result still pending,
// the block holds its next result until the register is free.
// Reset empties the heap and sets max_gap to 0; heap RAM is not cleared,
// since only live entries are ever read.
`default_nettype none

module k_way_merge_heap #(
    parameter int MAX_STREAMS = kwmh_pkg::DEFAULT_MAX_STREAMS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [kwmh_pkg::KEY_W-1:0]           i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [1:0]                           i_cmd,
    input  wire logic [kwmh_pkg::SID_W-1:0]           i_stream_id,
    input  wire logic [kwmh_pkg::KEY_W-1:0]           i_new_key,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic      [kwmh_pkg::SID_W-1:0]           o_head_stream,
    output logic      [kwmh_pkg::KEY_W-1:0]           o_head_key,
    output logic      [$clog2(MAX_STREAMS+1)-1:0]     o_entry_total,
    output logic                                      o_empty_res,
    output logic      [1:0]                           o_status
);

    localparam int IDX_W = $clog2(MAX_STREAMS);
    localparam int CNT_W = $clog2(MAX_STREAMS + 1);
    localparam int LW    = IDX_W + 2;
    localparam int KW    = kwmh_pkg::KEY_W;

    kwmh_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [KW-1:0]    r_gap;

    logic [IDX_W-1:0]       r_pos, n_pos;
    kwmh_pkg::t_entry       r_cur, n_cur;
    kwmh_pkg::t_entry       r_head, n_head;
    logic [KW-1:0]          r_key, n_key;
    logic [KW-1:0]          r_bound, n_bound;
    kwmh_pkg::t_status      r_status, n_status;

    logic [kwmh_pkg::SID_W-1:0] r_out_stream, n_out_stream;
    logic [KW-1:0]              r_out_key, n_out_key;
    logic [CNT_W-1:0]           r_out_total, n_out_total;
    logic                       r_out_empty, n_out_empty;
    kwmh_pkg::t_status          r_out_status, n_out_status;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    kwmh_pkg::t_entry       w_wdata;
    logic [IDX_W-1:0]       w_raddr_a, w_raddr_b;
    kwmh_pkg::t_entry       w_rdata_a, w_rdata_b;

    logic [LW-1:0]          w_left, w_right, w_count_ext;
    logic [IDX_W-1:0]       w_parent;
    logic [CNT_W-1:0]       w_count_m1;
    logic [KW:0]            w_sum;
    logic                   w_accept, w_full, w_out_free;
    logic                   w_no_left, w_pick_right, w_dn_stop, w_up_stop;
    kwmh_pkg::t_cmd         w_cmd;

    kwmh_ram #(
        .WIDTH ($bits(kwmh_pkg::t_entry)),
        .DEPTH (MAX_STREAMS)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign w_cmd       = kwmh_pkg::t_cmd'(i_cmd);
    assign w_left      = {1'b0, r_pos, 1'b1};
    assign w_right     = w_left + LW'(1);
    assign w_count_ext = LW'(r_count);
    assign w_parent    = (r_pos - IDX_W'(1)) >> 1;
    assign w_count_m1  = r_count - CNT_W'(1);
    assign w_full      = (r_count == CNT_W'(MAX_STREAMS));
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_sum       = {1'b0, r_head.key} + {1'b0, r_gap};
    assign w_accept    = (r_key > r_head.key) && (r_key < r_bound);
    assign w_no_left   = (w_left >= w_count_ext);

    // The three compares run side by side; the child pick only selects.
    assign w_pick_right = (w_right < w_count_ext) && (w_rdata_b.key < w_rdata_a.key);
    assign w_dn_stop    = w_pick_right ? (r_cur.key <= w_rdata_b.key)
                                       : (r_cur.key <= w_rdata_a.key);
    assign w_up_stop    = (r_cur.key >= w_rdata_a.key);

    assign n_head = (w_we && (w_waddr == '0)) ? w_wdata : r_head;

    always_comb begin
        n_state = r_state;
        case (r_state)
            kwmh_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (w_cmd)
                        kwmh_pkg::CMD_INSERT:
                            n_state = w_full ? kwmh_pkg::S_FINISH : kwmh_pkg::S_UP_CHK;
                        kwmh_pkg::CMD_ADVANCE:
                            n_state = (r_count == '0) ? kwmh_pkg::S_FINISH
                                                      : kwmh_pkg::S_BOUND;
                        kwmh_pkg::CMD_END:
                            n_state = (r_count == '0) ? kwmh_pkg::S_FINISH
                                                      : kwmh_pkg::S_DROP;
                        default: n_state = kwmh_pkg::S_FINISH;
                    endcase
                end
            end
            kwmh_pkg::S_BOUND:   n_state = kwmh_pkg::S_DECIDE;
            kwmh_pkg::S_DECIDE:
                n_state = w_accept ? kwmh_pkg::S_DN_RD : kwmh_pkg::S_DROP;
            kwmh_pkg::S_DROP:    n_state = kwmh_pkg::S_DROP_LD;
            kwmh_pkg::S_DROP_LD:
                n_state = (r_count == '0) ? kwmh_pkg::S_FINISH : kwmh_pkg::S_DN_RD;
            kwmh_pkg::S_DN_RD:
                n_state = w_no_left ? kwmh_pkg::S_FINISH : kwmh_pkg::S_DN_CMP;
            kwmh_pkg::S_DN_CMP:
                n_state = w_dn_stop ? kwmh_pkg::S_FINISH : kwmh_pkg::S_DN_RD;
            kwmh_pkg::S_UP_CHK:
                n_state = (r_pos == '0) ? kwmh_pkg::S_FINISH : kwmh_pkg::S_UP_CMP;
            kwmh_pkg::S_UP_CMP:
                n_state = w_up_stop ? kwmh_pkg::S_FINISH : kwmh_pkg::S_UP_CHK;
            kwmh_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = kwmh_pkg::S_IDLE;
                end
            end
            default: n_state = kwmh_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_key        = r_key;
        n_bound      = r_bound;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_stream = r_out_stream;
        n_out_key    = r_out_key;
        n_out_total  = r_out_total;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_cur;
        w_raddr_a    = '0;
        w_raddr_b    = '0;
        case (r_state)
            kwmh_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_status = kwmh_pkg::ST_OK;
                    n_key    = i_new_key;
                    case (w_cmd)
                        kwmh_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_status = kwmh_pkg::ST_FULL;
                            end else begin
                                n_cur.key = i_new_key;
                                n_cur.sid = i_stream_id;
                                n_pos     = r_count[IDX_W-1:0];
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        kwmh_pkg::CMD_ADVANCE, kwmh_pkg::CMD_END: begin
                            if (r_count == '0) begin
                                n_status = kwmh_pkg::ST_EMPTY;
                            end
                        end
                        default: n_count = '0;
                    endcase
                end
            end
            kwmh_pkg::S_BOUND: begin
                // old key plus gap, saturated to the largest key
                n_bound = w_sum[KW] ? {KW{1'b1}} : w_sum[KW-1:0];
            end
            kwmh_pkg::S_DECIDE: begin
                if (w_accept) begin
                    n_cur.key = r_key;
                    n_cur.sid = r_head.sid;
                    n_pos     = '0;
                end else begin
                    n_status = kwmh_pkg::ST_REJECT;
                end
            end
            kwmh_pkg::S_DROP: begin
                n_count   = w_count_m1;
                w_raddr_a = w_count_m1[IDX_W-1:0];
            end
            kwmh_pkg::S_DROP_LD: begin
                n_cur = w_rdata_a;
                n_pos = '0;
            end
            kwmh_pkg::S_DN_RD: begin
                if (w_no_left) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr_a = w_left[IDX_W-1:0];
                    w_raddr_b = w_right[IDX_W-1:0];
                end
            end
            kwmh_pkg::S_DN_CMP: begin
                w_we = 1'b1;
                if (!w_dn_stop) begin
                    w_wdata = w_pick_right ? w_rdata_b : w_rdata_a;
                    n_pos   = w_pick_right ? w_right[IDX_W-1:0] : w_left[IDX_W-1:0];
                end
            end
            kwmh_pkg::S_UP_CHK: begin
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr_a = w_parent;
                end
            end
            kwmh_pkg::S_UP_CMP: begin
                w_we = 1'b1;
                if (!w_up_stop) begin
                    w_wdata = w_rdata_a;
                    n_pos   = w_parent;
                end
            end
            kwmh_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_total  = r_count;
                    n_out_status = r_status;
                    n_out_empty  = (r_count == '0);
                    n_out_stream = (r_count == '0) ? '0 : r_head.sid;
                    n_out_key    = (r_count == '0) ? '0 : r_head.key;
                end
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kwmh_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_gap       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_head       <= n_head;
        r_key        <= n_key;
        r_bound      <= n_bound;
        r_status     <= n_status;
        r_out_stream <= n_out_stream;
        r_out_key    <= n_out_key;
        r_out_total  <= n_out_total;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign o_ready       = (r_state == kwmh_pkg::S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_head_stream = r_out_stream;
    assign o_head_key    = r_out_key;
    assign o_entry_total = r_out_total;
    assign o_empty_res   = r_out_empty;
    assign o_status      = r_out_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STREAMS))
        else $error("heap count above capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_empty_res == (o_entry_total == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == kwmh_pkg::ST_FULL)) |->
        (o_entry_total == CNT_W'(MAX_STREAMS)))
        else $error("full status with room left");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kwmh_pkg::S_FINISH) && w_out_free) |=> o_valid)
        else $error("finished result not presented");

    a_sift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kwmh_pkg::S_DN_CMP) |-> (CNT_W'(r_pos) < r_count))
        else $error("sift position outside live entries");
`endif

endmodule

`default_nettype wire

// ----- hdl/kwmh_ram.sv -----
`default_nettype none

module kwmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire
